// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/wdr_pkg.sv =====
// ----------------------------------------------------------------------------
// wdr_pkg
// shared types and codes of the wake doorbell epoch record
// ----------------------------------------------------------------------------
package wdr_pkg;

    typedef enum logic [1:0] {
        MODE_PUBLISH = 2'd0,
        MODE_OBSERVE = 2'd1,
        MODE_ACK     = 2'd2,
        MODE_RETAIN  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_APPLIED   = 4'd0,
        ST_WRONG     = 4'd1,
        ST_FAILED    = 4'd2,
        ST_CORRUPT   = 4'd3,
        ST_STALE     = 4'd4,
        ST_CONFLICT  = 4'd5,
        ST_EXHAUSTED = 4'd6,
        ST_OBSERVED  = 4'd7,
        ST_IDLE      = 4'd8,
        ST_REPEATED  = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        RS_CORRUPT   = 3'd0,
        RS_FAILED    = 3'd1,
        RS_PENDING   = 3'd2,
        RS_EXHAUSTED = 3'd3,
        RS_IDLE      = 3'd4,
        RS_ACKED     = 3'd5
    } rec_state_t;

    localparam logic [1:0] CFG_PUBLISHER_ID = 2'd0;
    localparam logic [1:0] CFG_CONSUMER_ID  = 2'd1;
    localparam logic [1:0] CFG_INITIAL      = 2'd2;

    localparam int PARTY_BITS = 3;
    localparam int PORT_EPOCH_BITS = 64;

    // latched flags of the record
    typedef struct packed {
        logic exhausted;
        logic failure;
    } flags_t;

    // per-item verdict
    typedef struct packed {
        status_t    status;
        rec_state_t rec_state;
    } verdict_t;

endpackage

// ===== src/wdr_step.sv =====
// ----------------------------------------------------------------------------
// wdr_step
// decision logic for one access: status, observed epoch and next record state
// ----------------------------------------------------------------------------
module wdr_step #(
    parameter int EPOCH_BITS = 64
) (
    input  wdr_pkg::mode_t          mode,
    input  logic [2:0]              party,
    input  logic [EPOCH_BITS-1:0]   arg,
    input  logic [2:0]              publisher_id,
    input  logic [2:0]              consumer_id,
    input  logic [EPOCH_BITS-1:0]   start_epoch,
    input  logic [EPOCH_BITS-1:0]   pub_count,
    input  logic [EPOCH_BITS-1:0]   ack_count,
    input  wdr_pkg::flags_t         flags,
    input  logic [EPOCH_BITS-1:0]   fail_epoch,
    output wdr_pkg::verdict_t       verdict,
    output logic [EPOCH_BITS-1:0]   seen,
    output logic [EPOCH_BITS-1:0]   pub_count_next,
    output logic [EPOCH_BITS-1:0]   ack_count_next,
    output wdr_pkg::flags_t         flags_next,
    output logic [EPOCH_BITS-1:0]   fail_epoch_next
);
    import wdr_pkg::*;

    logic    corrupt;
    logic    arg_lt_pub;
    logic    arg_eq_pub;
    logic    arg_lt_ack;
    logic    arg_eq_ack;
    logic    arg_lt_fail;
    logic    arg_eq_fail;
    logic    pub_max;
    status_t st;

    assign corrupt     = ack_count > pub_count;
    assign arg_lt_pub  = arg < pub_count;
    assign arg_eq_pub  = arg == pub_count;
    assign arg_lt_ack  = arg < ack_count;
    assign arg_eq_ack  = arg == ack_count;
    assign arg_lt_fail = arg < fail_epoch;
    assign arg_eq_fail = arg == fail_epoch;
    assign pub_max     = &pub_count;

    always_comb
    begin
        st              = ST_APPLIED;
        seen            = '0;
        pub_count_next  = pub_count;
        ack_count_next  = ack_count;
        flags_next      = flags;
        fail_epoch_next = fail_epoch;
        unique case (mode)
            MODE_PUBLISH:
            begin
                priority if (party != publisher_id) st = ST_WRONG;
                else if (flags.failure)             st = ST_FAILED;
                else if (corrupt)                   st = ST_CORRUPT;
                else if (arg_lt_pub)                st = ST_STALE;
                else if (!arg_eq_pub)               st = ST_CONFLICT;
                else if (pub_max)
                begin
                    st                   = ST_EXHAUSTED;
                    flags_next.exhausted = 1'b1;
                end
                else
                begin
                    pub_count_next = pub_count + 1'b1;
                end
            end
            MODE_OBSERVE:
            begin
                priority if (party != consumer_id) st = ST_WRONG;
                else if (flags.failure)
                begin
                    st   = ST_FAILED;
                    seen = pub_count;
                end
                else if (corrupt) st = ST_CORRUPT;
                else
                begin
                    seen = pub_count;
                    priority if (arg_eq_pub)
                        st = flags.exhausted ? ST_EXHAUSTED : ST_IDLE;
                    else if (!arg_lt_pub) st = ST_CONFLICT;
                    else                  st = ST_OBSERVED;
                end
            end
            MODE_ACK:
            begin
                priority if (party != consumer_id)   st = ST_WRONG;
                else if (flags.failure)              st = ST_FAILED;
                else if (corrupt)                    st = ST_CORRUPT;
                else if (arg_lt_ack)                 st = ST_STALE;
                else if (arg_eq_ack)                 st = ST_REPEATED;
                else if (!arg_lt_pub && !arg_eq_pub) st = ST_CONFLICT;
                else                                 ack_count_next = arg;
            end
            MODE_RETAIN:
            begin
                priority if (party != consumer_id) st = ST_WRONG;
                else if (flags.exhausted)          st = ST_EXHAUSTED;
                else if (flags.failure)
                begin
                    priority if (arg_eq_fail) st = ST_REPEATED;
                    else if (arg_lt_fail)     st = ST_STALE;
                    else                      st = ST_CONFLICT;
                end
                else if (corrupt)                  st = ST_CORRUPT;
                else if (arg_lt_pub)               st = ST_STALE;
                else if (!arg_eq_pub || arg_eq_ack) st = ST_CONFLICT;
                else
                begin
                    fail_epoch_next    = arg;
                    flags_next.failure = 1'b1;
                end
            end
            default: st = ST_APPLIED;
        endcase
    end

    // a corrupt record leaves every access unchanged, and a sound one stays sound
    always_comb
    begin
        verdict.status = st;
        priority if (corrupt)                        verdict.rec_state = RS_CORRUPT;
        else if (flags_next.failure)                 verdict.rec_state = RS_FAILED;
        else if (pub_count_next != ack_count_next)   verdict.rec_state = RS_PENDING;
        else if (flags_next.exhausted)               verdict.rec_state = RS_EXHAUSTED;
        else if (pub_count_next == start_epoch)      verdict.rec_state = RS_IDLE;
        else                                         verdict.rec_state = RS_ACKED;
    end

endmodule

// ===== src/wake_doorbell_epoch_record.sv =====
// ----------------------------------------------------------------------------
// wake_doorbell_epoch_record
// epoch-keyed doorbell between one publisher and one consumer
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | mode, party, epoch_arg
//  out     | out_valid / out_ready| status, seen_epoch, record_state
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  one access per cycle sustained unless the result channel stalls; an access
//  passes through the input register and then the result register
//  the record state is read and updated in the same cycle, so back to back
//  accesses see each other's effects
//  reset clears the record to epoch zero, publisher 0 and consumer 1
//  a stalled result keeps the input register full; in_ready drops only then
//  cfg is always ready; writing the start epoch register restarts the record
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wake_doorbell_epoch_record #(
    parameter int EPOCH_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // access channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [2:0]  party,
    input  logic [63:0] epoch_arg,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [63:0] seen_epoch,
    output logic [2:0]  record_state,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import wdr_pkg::*;

    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;

    // configuration
    logic [2:0]            publisher_id_reg;
    logic [2:0]            consumer_id_reg;
    logic [EPOCH_BITS-1:0] start_epoch_reg;

    // record state
    logic [EPOCH_BITS-1:0] pub_count_reg;
    logic [EPOCH_BITS-1:0] ack_count_reg;
    flags_t                flags_reg;
    logic [EPOCH_BITS-1:0] fail_epoch_reg;

    logic [EPOCH_BITS-1:0] pub_count_next;
    logic [EPOCH_BITS-1:0] ack_count_next;
    flags_t                flags_next;
    logic [EPOCH_BITS-1:0] fail_epoch_next;

    // input register
    logic                  in_valid_reg;
    mode_t                 mode_reg;
    logic [2:0]            party_reg;
    logic [EPOCH_BITS-1:0] arg_reg;

    // result register
    logic                  out_valid_reg;
    verdict_t              verdict_reg;
    logic [EPOCH_BITS-1:0] seen_reg;

    verdict_t              verdict;
    logic [EPOCH_BITS-1:0] seen;

    logic in_xfer;
    logic advance;
    logic cfg_xfer;
    logic init_write;

    // the held access steps whenever the result register is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !in_valid_reg || advance;
    assign in_xfer    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_xfer   = cfg_valid && cfg_ready;
    assign init_write = cfg_xfer && (cfg_index == CFG_INITIAL);

    wdr_step #(
        .EPOCH_BITS (EPOCH_BITS)
    ) u_step (
        .mode            (mode_reg),
        .party           (party_reg),
        .arg             (arg_reg),
        .publisher_id    (publisher_id_reg),
        .consumer_id     (consumer_id_reg),
        .start_epoch     (start_epoch_reg),
        .pub_count       (pub_count_reg),
        .ack_count       (ack_count_reg),
        .flags           (flags_reg),
        .fail_epoch      (fail_epoch_reg),
        .verdict         (verdict),
        .seen            (seen),
        .pub_count_next  (pub_count_next),
        .ack_count_next  (ack_count_next),
        .flags_next      (flags_next),
        .fail_epoch_next (fail_epoch_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            publisher_id_reg <= 3'd0;
            consumer_id_reg  <= 3'd1;
            start_epoch_reg  <= '0;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                CFG_PUBLISHER_ID: publisher_id_reg <= cfg_data[PARTY_BITS-1:0];
                CFG_CONSUMER_ID:  consumer_id_reg  <= cfg_data[PARTY_BITS-1:0];
                CFG_INITIAL:      start_epoch_reg  <= cfg_data[EPOCH_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // record state: a fresh record on a start epoch write, else the step result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pub_count_reg  <= '0;
            ack_count_reg  <= '0;
            flags_reg      <= '0;
            fail_epoch_reg <= '0;
        end
        else if (init_write)
        begin
            pub_count_reg  <= cfg_data[EPOCH_BITS-1:0];
            ack_count_reg  <= cfg_data[EPOCH_BITS-1:0];
            flags_reg      <= '0;
            fail_epoch_reg <= '0;
        end
        else if (advance)
        begin
            pub_count_reg  <= pub_count_next;
            ack_count_reg  <= ack_count_next;
            flags_reg      <= flags_next;
            fail_epoch_reg <= fail_epoch_next;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg  <= mode_t'(mode);
            party_reg <= party;
            arg_reg   <= epoch_arg[EPOCH_BITS-1:0];
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            verdict_reg <= verdict;
            seen_reg    <= seen;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = verdict_reg.status;
    assign record_state = verdict_reg.rec_state;
    assign seen_epoch   = PORT_EPOCH_BITS'(seen_reg);

    // accesses never leave the acknowledged epoch ahead of the published one
    `ASSERT_ALWAYS(a_ack_within_pub, ack_count_reg <= pub_count_reg,
        "acknowledged epoch ahead of published epoch")

    // exhaustion only latches with the counter parked at its maximum
    `ASSERT_ALWAYS(a_exhausted_at_max, !flags_reg.exhausted || pub_count_reg == EPOCH_MAX,
        "exhausted flag set below the maximum epoch")

    // a retained failure pins the published epoch it was taken at
    `ASSERT_ALWAYS(a_failure_pins_pub, !flags_reg.failure || fail_epoch_reg == pub_count_reg,
        "failure epoch differs from published epoch")

    // an applied publish moves the counter by exactly one
    `ASSERT_NEXT(a_publish_step,
        advance && !init_write && mode_reg == MODE_PUBLISH && verdict.status == ST_APPLIED,
        pub_count_reg == $past(pub_count_reg) + 1'b1,
        "applied publish did not advance the published epoch by one")

endmodule

// ===== sim/tb_wake_doorbell_epoch_record.sv =====
// ----------------------------------------------------------------------------
// tb_wake_doorbell_epoch_record
// self-checking bench for the epoch-keyed wake doorbell record: a model of
// the record in the bench predicts status, observed epoch and record state
// for every access transfer and each result transfer is compared in order,
// under random idling on both channels and one long result stall
// ----------------------------------------------------------------------------
module tb_wake_doorbell_epoch_record;
    timeunit 1ns;
    timeprecision 1ps;

    import wdr_pkg::*;

    localparam int EPOCH_BITS = 64;
    localparam logic [63:0] EPOCH_MASK = {64{1'b1}} >> (64 - EPOCH_BITS);
    // index outside the register map, the block must ignore it
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    // spare cycles after the last result, to be sure the block is quiet
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_PHASES = 12;
    localparam int ACCESSES_PER_PHASE = 100;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  party;
        logic [63:0] arg;
    } access_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] seen;
        rec_state_t  rstate;
    } doorbell_result_t;

    // dut ports, every input known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = '0;
    logic [2:0]  party = '0;
    logic [63:0] epoch_arg = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  status;
    logic [63:0] seen_epoch;
    logic [2:0]  record_state;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // predicted record: registers
    logic [2:0]  pub_sel = 3'd0;
    logic [2:0]  con_sel = 3'd1;
    logic [63:0] base_epoch = '0;
    // predicted record: state
    logic [63:0] pub_epoch = '0;
    logic [63:0] acked_epoch = '0;
    logic        exhausted_latched = 1'b0;
    logic        failure_latched = 1'b0;
    logic [63:0] failure_mark = '0;

    doorbell_result_t expected_results[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // idling controls
    logic        tx_idle_on = 1'b1;
    logic        rx_idle_on = 1'b1;
    logic        rx_hold_tgl = 1'b0;
    logic        rx_hold_seen = 1'b0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_burst_left = 0;

    wake_doorbell_epoch_record #(
        .EPOCH_BITS(EPOCH_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .party         (party),
        .epoch_arg     (epoch_arg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .seen_epoch    (seen_epoch),
        .record_state  (record_state),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // record prediction
    // ------------------------------------------------------------------------

    // apply one access to the predicted record and return what it reports
    function automatic doorbell_result_t advance_record(mode_t m, logic [2:0] who,
                                                       logic [63:0] arg_in);
        doorbell_result_t r;
        logic [63:0] a;
        logic        corrupt;
        a = arg_in & EPOCH_MASK;
        r.seen = '0;
        corrupt = acked_epoch > pub_epoch;
        case (m)
            MODE_PUBLISH:
            begin
                if (who != pub_sel)
                    r.status = ST_WRONG;
                else if (failure_latched)
                    r.status = ST_FAILED;
                else if (corrupt)
                    r.status = ST_CORRUPT;
                else if (a < pub_epoch)
                    r.status = ST_STALE;
                else if (a > pub_epoch)
                    r.status = ST_CONFLICT;
                else if (pub_epoch == EPOCH_MASK)
                begin
                    // counter saturates, no wrap
                    exhausted_latched = 1'b1;
                    r.status = ST_EXHAUSTED;
                end
                else
                begin
                    pub_epoch = (pub_epoch + 64'd1) & EPOCH_MASK;
                    r.status = ST_APPLIED;
                end
            end
            MODE_OBSERVE:
            begin
                if (who != con_sel)
                    r.status = ST_WRONG;
                else if (failure_latched)
                begin
                    r.seen = pub_epoch;
                    r.status = ST_FAILED;
                end
                else if (corrupt)
                    r.status = ST_CORRUPT;
                else
                begin
                    r.seen = pub_epoch;
                    if (a > pub_epoch)
                        r.status = ST_CONFLICT;
                    else if (a == pub_epoch)
                        r.status = exhausted_latched ? ST_EXHAUSTED : ST_IDLE;
                    else
                        r.status = ST_OBSERVED;
                end
            end
            MODE_ACK:
            begin
                if (who != con_sel)
                    r.status = ST_WRONG;
                else if (failure_latched)
                    r.status = ST_FAILED;
                else if (corrupt)
                    r.status = ST_CORRUPT;
                else if (a < acked_epoch)
                    r.status = ST_STALE;
                else if (a == acked_epoch)
                    r.status = ST_REPEATED;
                else if (a > pub_epoch)
                    r.status = ST_CONFLICT;
                else
                begin
                    acked_epoch = a;
                    r.status = ST_APPLIED;
                end
            end
            default:
            begin
                // retain failure
                if (who != con_sel)
                    r.status = ST_WRONG;
                else if (exhausted_latched)
                    r.status = ST_EXHAUSTED;
                else if (failure_latched)
                begin
                    if (a == failure_mark)
                        r.status = ST_REPEATED;
                    else if (a < failure_mark)
                        r.status = ST_STALE;
                    else
                        r.status = ST_CONFLICT;
                end
                else if (corrupt)
                    r.status = ST_CORRUPT;
                else if (a < pub_epoch)
                    r.status = ST_STALE;
                else if (a > pub_epoch || a == acked_epoch)
                    r.status = ST_CONFLICT;
                else
                begin
                    failure_mark = a;
                    failure_latched = 1'b1;
                    r.status = ST_APPLIED;
                end
            end
        endcase

        // overall state after the step
        if (acked_epoch > pub_epoch)
            r.rstate = RS_CORRUPT;
        else if (failure_latched)
            r.rstate = RS_FAILED;
        else if (pub_epoch != acked_epoch)
            r.rstate = RS_PENDING;
        else if (exhausted_latched)
            r.rstate = RS_EXHAUSTED;
        else if (pub_epoch == base_epoch)
            r.rstate = RS_IDLE;
        else
            r.rstate = RS_ACKED;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random access generation
    // ------------------------------------------------------------------------

    function automatic logic [63:0] random_epoch();
        return {$urandom, $urandom};
    endfunction

    // uniform pick in [lo, hi], lo <= hi
    function automatic logic [63:0] epoch_between(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] span;
        span = hi - lo;
        if (span == {64{1'b1}})
            return random_epoch();
        return lo + (random_epoch() % (span + 64'd1));
    endfunction

    // mostly accesses that follow the protocol against the current record,
    // the rest noise with any mode, party and epoch
    function automatic access_t draw_access();
        access_t acc;
        int unsigned pick;
        acc.mode = mode_t'(2'($urandom_range(0, 3)));
        acc.party = 3'($urandom_range(0, 7));
        acc.arg = random_epoch();
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return acc;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            acc.mode = MODE_PUBLISH;
            acc.party = pub_sel;
            acc.arg = pub_epoch;
            // off by one now and then: stale or conflict
            if ($urandom_range(0, 7) == 0)
                acc.arg = acc.arg + ($urandom_range(0, 1) ? 64'd1 : {64{1'b1}});
        end
        else if (pick < 65)
        begin
            acc.mode = MODE_OBSERVE;
            acc.party = con_sel;
            if ($urandom_range(0, 9) == 0)
                acc.arg = pub_epoch + 64'd1;
            else if ($urandom_range(0, 2) == 0)
                acc.arg = pub_epoch;
            else
                acc.arg = epoch_between(acked_epoch, pub_epoch);
        end
        else if (pick < 95)
        begin
            acc.mode = MODE_ACK;
            acc.party = con_sel;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                acc.arg = acked_epoch;
            else if (pick == 1)
                acc.arg = acked_epoch - 64'd1;
            else if (pick == 2)
                acc.arg = pub_epoch + 64'd1;
            else if (pub_epoch != acked_epoch)
                acc.arg = epoch_between(acked_epoch + 64'd1, pub_epoch);
            else
                acc.arg = acked_epoch;
        end
        else
        begin
            acc.mode = MODE_RETAIN;
            acc.party = con_sel;
            if (failure_latched)
                acc.arg = failure_mark + 64'($signed($urandom_range(0, 2)) - 1);
            else
                acc.arg = pub_epoch;
        end
        return acc;
    endfunction

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------

    // one access transfer; in_valid stays high afterwards so a following
    // access goes out back to back, a gap or a register write lowers it
    task automatic send_access(mode_t m, logic [2:0] who, logic [63:0] arg);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        party <= who;
        epoch_arg <= arg;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(advance_record(m, who, arg));
    endtask

    task automatic send_random_access();
        access_t acc;
        acc = draw_access();
        send_access(acc.mode, acc.party, acc.arg);
    endtask

    // register write, only once the record has gone quiet
    task automatic write_register(logic [1:0] idx, logic [63:0] value);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PUBLISHER_ID: pub_sel = value[2:0];
            CFG_CONSUMER_ID:  con_sel = value[2:0];
            CFG_INITIAL:
            begin
                // fresh record from the new epoch
                base_epoch = value & EPOCH_MASK;
                pub_epoch = base_epoch;
                acked_epoch = base_epoch;
                exhausted_latched = 1'b0;
                failure_latched = 1'b0;
                failure_mark = '0;
            end
            default: ;
        endcase
    endtask

    // result side: bursts of ready and of stall, plus a long hold on request
    always @(posedge clk)
    begin
        if (rx_hold_tgl != rx_hold_seen)
        begin
            rx_hold_seen <= rx_hold_tgl;
            rx_hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (rx_burst_left != 0)
            rx_burst_left <= rx_burst_left - 1;
        else if (rx_idle_on && $urandom_range(0, 2) == 0)
        begin
            // stall of random length, this cycle included
            rx_burst_left <= $urandom_range(0, 11);
            out_ready <= 1'b0;
        end
        else
        begin
            rx_burst_left <= $urandom_range(0, 15);
            out_ready <= 1'b1;
        end
    end

    // in-order compare of each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        doorbell_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no access outstanding: status %0d", status);
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count = error_count + 1;
                end
                if (seen_epoch !== want.seen)
                begin
                    $error("seen_epoch: expected %0h, got %0h", want.seen, seen_epoch);
                    error_count = error_count + 1;
                end
                if (record_state !== want.rstate)
                begin
                    $error("record_state: expected %0d, got %0d", want.rstate, record_state);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values: publisher 0, consumer 1, epoch zero
    task automatic test_default_record();
        send_access(MODE_OBSERVE, 3'd1, 64'd0);          // idle
        send_access(MODE_PUBLISH, 3'd0, 64'd0);          // applied, pending
        send_access(MODE_PUBLISH, 3'd3, 64'd1);          // wrong party
        send_access(MODE_PUBLISH, 3'd0, 64'd0);          // stale
        send_access(MODE_PUBLISH, 3'd0, 64'd5);          // conflict
        send_access(MODE_OBSERVE, 3'd1, 64'd0);          // observed, seen 1
        send_access(MODE_OBSERVE, 3'd1, 64'd2);          // conflict
        send_access(MODE_ACK, 3'd1, 64'd0);              // repeated
        send_access(MODE_ACK, 3'd1, 64'd2);              // beyond published
        send_access(MODE_ACK, 3'd1, 64'd1);              // applied, acknowledged
        send_access(MODE_ACK, 3'd0, 64'd1);              // wrong party
        send_access(MODE_OBSERVE, 3'd1, {64{1'b1}});     // all ones argument
    endtask

    // counter at its maximum latches exhaustion instead of wrapping
    task automatic test_counter_limit();
        write_register(CFG_UNUSED, random_epoch());
        write_register(CFG_INITIAL, EPOCH_MASK - 64'd1);
        send_access(MODE_PUBLISH, 3'd0, EPOCH_MASK - 64'd1);
        send_access(MODE_PUBLISH, 3'd0, EPOCH_MASK);     // exhausted
        send_access(MODE_OBSERVE, 3'd1, EPOCH_MASK);
        send_access(MODE_RETAIN, 3'd1, EPOCH_MASK);      // retain after exhaustion
        send_access(MODE_ACK, 3'd1, EPOCH_MASK);
    endtask

    // failure latch and its repeat / stale / conflict answers, one party
    // holding both roles at the top party number
    task automatic test_failure_latch();
        write_register(CFG_PUBLISHER_ID, 64'd7);
        write_register(CFG_CONSUMER_ID, 64'hffff_ffff_ffff_fff7);
        write_register(CFG_INITIAL, 64'd0);
        send_access(MODE_PUBLISH, 3'd7, 64'd0);
        send_access(MODE_RETAIN, 3'd7, 64'd0);           // stale
        send_access(MODE_RETAIN, 3'd7, 64'd1);           // latches failure
        send_access(MODE_RETAIN, 3'd7, 64'd1);           // repeated
        send_access(MODE_RETAIN, 3'd7, 64'd0);
        send_access(MODE_RETAIN, 3'd7, 64'd2);
        send_access(MODE_PUBLISH, 3'd7, 64'd1);          // blocked by failure
        send_access(MODE_OBSERVE, 3'd7, 64'd0);
        send_access(MODE_ACK, 3'd7, 64'd1);
    endtask

    // result side holds off for a long stretch while accesses keep coming,
    // so the block fills and drops in_ready
    task automatic test_result_backpressure();
        write_register(CFG_PUBLISHER_ID, 64'd0);
        write_register(CFG_CONSUMER_ID, 64'd1);
        write_register(CFG_INITIAL, random_epoch());
        tx_idle_on = 1'b0;
        rx_hold_tgl <= ~rx_hold_tgl;
        repeat (20) send_random_access();
        tx_idle_on = 1'b1;
    endtask

    // phases of random accesses, each from a fresh random start epoch and party setup;
    // the closing phases run with no idling on either side
    task automatic test_random_accesses();
        int unsigned pick;
        logic [2:0]  pub_party;
        logic [2:0]  con_party;
        logic [63:0] start;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == RANDOM_PHASES - 2)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on <= 1'b0;
            end
            pub_party = 3'($urandom_range(0, 7));
            con_party = ($urandom_range(0, 4) == 0) ? pub_party : 3'($urandom_range(0, 7));
            pick = $urandom_range(0, 9);
            if (pick < 2)
                start = 64'd0;
            else if (pick < 5)
                start = EPOCH_MASK - 64'($urandom_range(0, 40));
            else
                start = random_epoch();
            // the publisher register is written with junk in its upper bits
            if ($urandom_range(0, 3) != 0)
                write_register(CFG_PUBLISHER_ID, {61'(random_epoch() >> 3), pub_party});
            if ($urandom_range(0, 3) != 0)
                write_register(CFG_CONSUMER_ID, {61'd0, con_party});
            if ($urandom_range(0, 5) == 0)
                write_register(CFG_UNUSED, random_epoch());
            write_register(CFG_INITIAL, start);
            repeat (ACCESSES_PER_PHASE) send_random_access();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_default_record();
        test_counter_limit();
        test_failure_latch();
        test_result_backpressure();
        test_random_accesses();

        // drain, then wait for anything unexpected to show up
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
